// ===== rtl/core/smv_pkg.sv =====
`timescale 1ns / 1ps
// smv_pkg: widths, sizes and sequencer states for sample_mean_variance
// no dependencies; imported by the channel interfaces and the top level

package smv_pkg;

   // store capacity and field widths
   localparam int MAX_SAMPLES = 256;
   localparam int SAMPLE_W    = 24;
   localparam int VAR_W       = 48;
   localparam int COUNT_W     = 9;

   // derived internal widths
   localparam int ADDR_W = $clog2(MAX_SAMPLES);
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = SAMPLE_W + ADDR_W;
   localparam int DIFF_W = SAMPLE_W + 1;
   localparam int SQR_W  = 2 * SAMPLE_W;
   localparam int ACC_W  = SQR_W + ADDR_W;
   localparam int DIV_W  = ACC_W;
   localparam int REM_W  = CNT_W + 1;
   localparam int ITER_W = $clog2(DIV_W + 1);

   typedef enum logic [5:0] {
      ST_LOAD      = 6'b000001,
      ST_MEAN_INIT = 6'b000010,
      ST_DIV_MEAN  = 6'b000100,
      ST_PASS      = 6'b001000,
      ST_DIV_VAR   = 6'b010000,
      ST_EMIT      = 6'b100000
   } state_type;

endpackage

// ===== rtl/core/smv_if.sv =====
`timescale 1ns / 1ps
// smv_req_if and smv_rsp_if: valid/ready channels of sample_mean_variance
// depends on smv_pkg for the field widths

interface smv_req_if
   import smv_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

interface smv_rsp_if
   import smv_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] mean;
   logic        [VAR_W-1:0]    variance;
   logic        [COUNT_W-1:0]  count;
   logic                       overflow;

   modport source (output valid, output mean, output variance, output count,
                   output overflow, input ready);
   modport sink   (input valid, input mean, input variance, input count,
                   input overflow, output ready);
endinterface

// ===== rtl/core/sample_mean_variance.sv =====
`timescale 1ns / 1ps
// Samples are taken one per cycle on req_ch while the block is loading, and written into a
// 256-entry store while a running sum is kept. The transfer marked last closes the set: the
// block then drops ready and runs a setup state, the mean division, a pass over the N stored
// samples (one ram read per cycle into a registered subtract and square), the variance
// division and a state that posts the result. Both divisions run on one shared restoring
// divider that retires one quotient bit per cycle. The result sits in an output register,
// and the next set is loaded while it waits; only posting a new result waits for rsp_ch to
// take the old one. Samples past the store capacity are dropped and reported in overflow.
// depends on smv_pkg, smv_if (channels) and smv_ram

module sample_mean_variance
   import smv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   smv_req_if.sink   req_ch,
   smv_rsp_if.source rsp_ch
);

   state_type state_ff, state_in;

   // set state
   logic        [CNT_W-1:0] count_ff, count_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    dropped_ff, dropped_in;

   // pass pipeline
   logic        [CNT_W-1:0]  idx_ff, idx_in;
   logic                     rd_vld_ff, rd_vld_in;
   logic                     d_vld_ff, d_vld_in;
   logic                     sq_vld_ff, sq_vld_in;
   logic signed [DIFF_W-1:0] d_ff, d_in;
   logic        [SQR_W-1:0]  sq_ff, sq_in;
   logic        [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0] mean_ff, mean_in;

   // shared divider
   logic              neg_ff, neg_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [ITER_W-1:0] iter_ff, iter_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_mean_ff, rsp_mean_in;
   logic        [VAR_W-1:0]    rsp_var_ff, rsp_var_in;
   logic        [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                       rsp_ovf_ff, rsp_ovf_in;

   logic                       req_xfer;
   logic                       has_room;
   logic                       wr_en;
   logic                       rd_en;
   logic        [SAMPLE_W-1:0] rd_data;
   logic        [REM_W-1:0]    rem_shift;
   logic        [REM_W-1:0]    cnt_ext;
   logic                       fits;
   logic        [REM_W-1:0]    rem_step;
   logic        [DIV_W-1:0]    quo_step;
   logic        [SUM_W-1:0]    sum_mag;
   logic        [SAMPLE_W-1:0] quo_low;
   logic signed [2*DIFF_W-1:0] prod;
   logic                       slot_free;

   assign req_xfer  = req_ch.valid && req_ch.ready;
   assign has_room  = count_ff < CNT_W'(MAX_SAMPLES);
   assign wr_en     = req_xfer && has_room;
   assign rd_en     = (state_ff == ST_PASS) && (idx_ff < count_ff);
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   smv_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(MAX_SAMPLES)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[ADDR_W-1:0]),
      .wr_data(req_ch.sample),
      .rd_en  (rd_en),
      .rd_addr(idx_ff[ADDR_W-1:0]),
      .rd_data(rd_data)
   );

   // one restoring divide step
   always_comb begin
      rem_shift = {rem_ff[REM_W-2:0], quo_ff[DIV_W-1]};
      cnt_ext   = {1'b0, count_ff};
      fits      = rem_shift >= cnt_ext;
      rem_step  = fits ? (rem_shift - cnt_ext) : rem_shift;
      quo_step  = {quo_ff[DIV_W-2:0], fits};
      quo_low   = quo_step[SAMPLE_W-1:0];
      sum_mag   = sum_ff[SUM_W-1] ? (~sum_ff + SUM_W'(1)) : sum_ff;
      prod      = d_ff * d_ff;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      dropped_in   = dropped_ff;
      idx_in       = idx_ff;
      rd_vld_in    = rd_en;
      d_vld_in     = rd_vld_ff;
      sq_vld_in    = d_vld_ff;
      d_in         = DIFF_W'(signed'(rd_data)) - DIFF_W'(mean_ff);
      sq_in        = prod[SQR_W-1:0];
      acc_in       = acc_ff;
      mean_in      = mean_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_mean_in  = rsp_mean_ff;
      rsp_var_in   = rsp_var_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               if (has_room) begin
                  count_in = count_ff + CNT_W'(1);
                  sum_in   = sum_ff + {{(SUM_W-SAMPLE_W){req_ch.sample[SAMPLE_W-1]}},
                                       req_ch.sample};
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_ch.last) begin
                  state_in = ST_MEAN_INIT;
               end
            end
         end
         ST_MEAN_INIT: begin
            // divide the magnitude, top-aligned so only SUM_W steps are needed
            neg_in   = sum_ff[SUM_W-1];
            rem_in   = '0;
            quo_in   = {sum_mag, {(DIV_W-SUM_W){1'b0}}};
            iter_in  = ITER_W'(SUM_W);
            state_in = ST_DIV_MEAN;
         end
         ST_DIV_MEAN: begin
            rem_in  = rem_step;
            quo_in  = quo_step;
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == ITER_W'(1)) begin
               mean_in  = neg_ff ? (~quo_low + SAMPLE_W'(1)) : quo_low;
               idx_in   = '0;
               acc_in   = '0;
               state_in = ST_PASS;
            end
         end
         ST_PASS: begin
            if (rd_en) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (sq_vld_ff) begin
               acc_in = acc_ff + ACC_W'(sq_ff);
            end
            if (!rd_en && !rd_vld_ff && !d_vld_ff && !sq_vld_ff) begin
               rem_in   = '0;
               quo_in   = acc_ff;
               iter_in  = ITER_W'(DIV_W);
               state_in = ST_DIV_VAR;
            end
         end
         ST_DIV_VAR: begin
            rem_in  = rem_step;
            quo_in  = quo_step;
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == ITER_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // wait until the previous result has been taken
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = mean_ff;
               rsp_var_in   = quo_ff[VAR_W-1:0];
               rsp_count_in = COUNT_W'(count_ff);
               rsp_ovf_in   = dropped_ff;
               count_in     = '0;
               sum_in       = '0;
               dropped_in   = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         sum_ff       <= '0;
         dropped_ff   <= 1'b0;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         d_vld_ff     <= 1'b0;
         sq_vld_ff    <= 1'b0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         dropped_ff   <= dropped_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_vld_in;
         d_vld_ff     <= d_vld_in;
         sq_vld_ff    <= sq_vld_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      acc_ff       <= acc_in;
      mean_ff      <= mean_in;
      neg_ff       <= neg_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_var_ff   <= rsp_var_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign req_ch.ready    = (state_ff == ST_LOAD);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.mean     = rsp_mean_ff;
   assign rsp_ch.variance = rsp_var_ff;
   assign rsp_ch.count    = rsp_count_ff;
   assign rsp_ch.overflow = rsp_ovf_ff;

endmodule

// ===== rtl/core/smv_ram.sv =====
`timescale 1ns / 1ps
// smv_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies

module smv_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for sample_mean_variance, sample sets in and statistics out
// depends on smv_pkg, smv_if and the sample_mean_variance rtl

module tb;
   import smv_pkg::*;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;
   localparam int HOLD_CYCLES   = 1500;
   localparam int QUIET_LIMIT   = 20000;
   localparam int TAIL_CYCLES   = 200;
   localparam int RANDOM_ITEMS  = 950;
   localparam int NO_IDLE_ITEMS = 200;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mean;
      logic [VAR_W-1:0]    variance;
      logic [COUNT_W-1:0]  count;
      logic                overflow;
   } set_stats_type;

   logic clock;
   logic reset;

   smv_req_if req_ch();
   smv_rsp_if rsp_ch();

   sample_mean_variance u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // statistics predictor state for the set being loaded
   logic [SAMPLE_W-1:0] set_store [MAX_SAMPLES];
   int                  set_len;
   longint              set_sum;
   logic                set_dropped;

   set_stats_type pending_stats [$];
   int            mismatches;
   int            quiet_cycles;
   bit            idle_on;
   bit            hold_req;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void accumulate_sample(input logic [SAMPLE_W-1:0] s, input logic lst);
      longint            mean_q;
      longint            d;
      longint unsigned   sq;
      longint unsigned   var_q;
      set_stats_type     r;
      if (set_len < MAX_SAMPLES) begin
         set_store[set_len] = s;
         set_sum = set_sum + longint'($signed(s));
         set_len++;
      end else begin
         set_dropped = 1'b1;
      end
      if (lst) begin
         mean_q = 0;
         sq     = 0;
         var_q  = 0;
         if (set_len > 0) begin
            // signed division truncates toward zero
            mean_q = set_sum / set_len;
            for (int i = 0; i < set_len; i++) begin
               d  = longint'($signed(set_store[i])) - mean_q;
               sq = sq + d * d;
            end
            var_q = sq / set_len;
         end
         r.mean     = mean_q[SAMPLE_W-1:0];
         r.variance = var_q[VAR_W-1:0];
         r.count    = set_len[COUNT_W-1:0];
         r.overflow = set_dropped;
         pending_stats.push_back(r);
         set_len     = 0;
         set_sum     = 0;
         set_dropped = 1'b0;
      end
   endfunction

   function automatic logic [SAMPLE_W-1:0] draw_sample(input logic [SAMPLE_W-1:0] center);
      int unsigned mode;
      logic [SAMPLE_W-1:0] s;
      mode = $urandom_range(0, 9);
      case (mode)
         0, 1, 2: s = SAMPLE_W'($urandom());
         3:       s = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
         4, 5:    s = SAMPLE_W'(int'($urandom_range(0, 255)) - 128);
         default: s = center + SAMPLE_W'(int'($urandom_range(0, 8191)) - 4096);
      endcase
      return s;
   endfunction

   // entered and left at a falling edge
   task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic lst);
      int gap;
      gap = idle_on ? int'($urandom_range(0, 7)) : 0;
      repeat (gap) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.sample <= s;
      req_ch.last   <= lst;
      do @(posedge clock); while (!req_ch.ready);
      accumulate_sample(s, lst);
      @(negedge clock);
   endtask

   task automatic send_set(input int len, input logic [SAMPLE_W-1:0] center);
      for (int i = 0; i < len; i++)
         send_sample(draw_sample(center), i == len - 1);
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (pending_stats.size() != 0)
         @(negedge clock);
      @(negedge clock);
   endtask

   task automatic test_directed_extremes();
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(SAMPLE_MIN, 1'b1);
      send_sample(24'h000000, 1'b1);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);
      // negative sums must truncate toward zero, not floor
      send_sample(24'hFFFFFF, 1'b0);
      send_sample(24'h000000, 1'b1);
      send_sample(24'hFFFFFD, 1'b0);
      send_sample(24'h000000, 1'b1);
      send_sample(24'h000001, 1'b0);
      send_sample(24'h000002, 1'b1);
      send_sample(24'h555555, 1'b0);
      send_sample(24'hAAAAAA, 1'b1);
      send_sample(24'h000005, 1'b0);
      send_sample(24'h000005, 1'b0);
      send_sample(24'h000005, 1'b1);
      wait_for_results();
   endtask

   task automatic test_store_full();
      // exactly full, no drop
      send_set(MAX_SAMPLES, SAMPLE_W'($urandom()));
      // two samples past capacity, the set closed by a dropped one
      for (int i = 0; i < MAX_SAMPLES + 2; i++)
         send_sample(i[0] ? SAMPLE_MIN : SAMPLE_MAX, i == MAX_SAMPLES + 1);
      wait_for_results();
   endtask

   task automatic test_random_sets();
      int sent;
      int len;
      int pick;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 75)
            len = $urandom_range(1, 12);
         else if (pick < 98)
            len = $urandom_range(13, 64);
         else
            len = $urandom_range(MAX_SAMPLES - 6, MAX_SAMPLES + 6);
         send_set(len, SAMPLE_W'($urandom()));
         sent += len;
      end
      wait_for_results();
   endtask

   task automatic test_output_stall();
      // receiver stops while several sets go in, so the input backs up
      hold_req = 1'b1;
      for (int i = 0; i < 4; i++)
         send_set(6, SAMPLE_W'($urandom()));
      wait_for_results();
   endtask

   task automatic test_no_idle();
      int sent;
      int len;
      sent    = 0;
      idle_on = 1'b0;
      while (sent < NO_IDLE_ITEMS) begin
         len = $urandom_range(1, 8);
         send_set(len, SAMPLE_W'($urandom()));
         sent += len;
      end
      wait_for_results();
      idle_on = 1'b1;
   endtask

   // receiver
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         stall = idle_on ? int'($urandom_range(0, 7)) : 0;
         repeat (stall) begin
            rsp_ch.ready <= 1'b0;
            @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!((rsp_ch.valid && rsp_ch.ready) || hold_req));
         @(negedge clock);
      end
   end

   // result checker
   always @(posedge clock) begin : check_results
      set_stats_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_stats.size() == 0) begin
            $error("unexpected result transfer: mean %0d count %0d",
                   rsp_ch.mean, rsp_ch.count);
            mismatches++;
         end else begin
            want = pending_stats.pop_front();
            if (rsp_ch.mean !== want.mean) begin
               $error("mean: expected %0d, got %0d", $signed(want.mean), rsp_ch.mean);
               mismatches++;
            end
            if (rsp_ch.variance !== want.variance) begin
               $error("variance: expected %0d, got %0d", want.variance, rsp_ch.variance);
               mismatches++;
            end
            if (rsp_ch.count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
               mismatches++;
            end
            if (rsp_ch.overflow !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_ch.overflow);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.sample = '0;
      req_ch.last   = 1'b0;
      idle_on       = 1'b1;
      hold_req      = 1'b0;
      mismatches    = 0;
      quiet_cycles  = 0;
      set_len       = 0;
      set_sum       = 0;
      set_dropped   = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_extremes();
      test_store_full();
      test_output_stall();
      test_random_sets();
      test_no_idle();

      wait_for_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
